FILE: src/iidl_pkg.sv
// Shared types and constants for the indexed insert/delete list.
// Used by iidl_cell and indexed_insert_delete_list; depends on nothing.
`default_nettype none

package iidl_pkg;

    localparam int KIND_W            = 3;
    localparam int POS_W             = 6;
    localparam int VALUE_W           = 32;
    localparam int COUNT_W           = 7;
    // Wide enough for any index or fill count up to the largest supported depth
    localparam int TGT_W             = 11;
    localparam int DEFAULT_DEPTH     = 64;
    localparam int DEFAULT_WORD_BITS = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH      = 3'd0,
        KIND_POP       = 3'd1,
        KIND_INSERT    = 3'd2,
        KIND_REMOVE    = 3'd3,
        KIND_READ      = 3'd4,
        KIND_OVERWRITE = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [TGT_W-1:0]   target;
        logic [TGT_W-1:0]   rd_target;
    } cell_ctrl_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

`default_nettype wire

FILE: src/iidl_cell.sv
// One storage cell of the list: holds a single entry and trades it with its neighbors.
// Depends on iidl_pkg.
`default_nettype none

module iidl_cell
    import iidl_pkg::*;
#(
    parameter int WIDTH = DEFAULT_WORD_BITS,
    parameter int INDEX = 0
)
(
    input  wire logic             clk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [WIDTH-1:0] value,
    input  wire logic [WIDTH-1:0] lower_word,
    input  wire logic [WIDTH-1:0] upper_word,
    output logic      [WIDTH-1:0] word,
    output logic      [WIDTH-1:0] rd_word
);

    localparam logic [TGT_W-1:0] MY_INDEX = TGT_W'(INDEX);

    logic [WIDTH-1:0] word_reg;
    logic [WIDTH-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (ctrl.op)
            CELL_WRITE:
            begin
                if (MY_INDEX == ctrl.target)
                    word_next = value;
            end
            CELL_SHIFT_UP:
            begin
                // take the lower neighbor above the insert point, the new word at it
                if (MY_INDEX > ctrl.target)
                    word_next = lower_word;
                else if (MY_INDEX == ctrl.target)
                    word_next = value;
            end
            CELL_SHIFT_DOWN:
            begin
                if (MY_INDEX >= ctrl.target)
                    word_next = upper_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (MY_INDEX == ctrl.rd_target) ? word_reg : '0;

endmodule

`default_nettype wire

FILE: src/indexed_insert_delete_list.sv
// Top level of the indexed insert/delete list: request decode, fill count, cell row, response.
// Depends on iidl_pkg and iidl_cell.
`default_nettype none

// Ordered list of up to DEPTH words held in a row of cells, one entry per cell.
// Each request transaction is push, pop, insert at an index, remove at an index,
// read or overwrite. Insert and remove move every affected entry by one place in
// the same clock edge, because each cell loads from its lower or upper neighbor.
// A request that cannot be carried out (bad index, pop from an empty list, push
// or insert into a full list, unknown kind) changes nothing and returns status 1.
// Every response carries the entry count after the request; read_value is the
// word returned by a successful pop or read and zero otherwise.
// Rate: one request per clock cycle, sustained while responses are taken. A request
// is decoded and applied to the cell row in the cycle it is accepted; its response
// appears in the response register on the next cycle. The response register is the
// only buffer: a new request is taken whenever that register is empty or its
// response is taken in the same cycle. Stored words are WORD_BITS wide, up to
// the 32 bits of the value field; no clearing pass after reset is needed.
module indexed_insert_delete_list
    import iidl_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int WORD_BITS = DEFAULT_WORD_BITS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int STORE_W = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Fill count and response register
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    // Decode results
    logic             accept;
    logic             ok;
    logic             returns_word;
    logic [CNT_W-1:0] fill_after;
    cell_op_t         op;
    logic [TGT_W-1:0] target;
    logic [TGT_W-1:0] rd_target;
    cell_ctrl_t       ctrl;

    logic [TGT_W-1:0] fill_ext;
    logic [TGT_W-1:0] pos_ext;
    logic             full;
    logic             empty;

    // Cell row
    logic [STORE_W-1:0] cell_word    [DEPTH];
    logic [STORE_W-1:0] cell_rd_word [DEPTH];
    logic [STORE_W-1:0] rd_word;
    logic [STORE_W-1:0] store_value;

    // Take a new request whenever the response slot is free or being drained
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign fill_ext    = TGT_W'(fill_reg);
    assign pos_ext     = TGT_W'(req.position);
    assign full        = (fill_reg == FULL_COUNT);
    assign empty       = (fill_reg == '0);
    assign store_value = req.value[STORE_W-1:0];

    // Decode the request kind into a cell command, a read select and the new count
    always_comb
    begin
        ok           = 1'b0;
        returns_word = 1'b0;
        op           = CELL_HOLD;
        target       = pos_ext;
        rd_target    = pos_ext;
        fill_after   = fill_reg;
        unique case (kind_t'(req.kind))
            KIND_PUSH:
            begin
                ok         = !full;
                op         = CELL_WRITE;
                target     = fill_ext;
                fill_after = CNT_W'(fill_reg + 1'b1);
            end
            KIND_POP:
            begin
                ok           = !empty;
                returns_word = 1'b1;
                rd_target    = TGT_W'(fill_ext - 1'b1);
                fill_after   = CNT_W'(fill_reg - 1'b1);
            end
            KIND_INSERT:
            begin
                ok         = !full && (pos_ext <= fill_ext);
                op         = CELL_SHIFT_UP;
                fill_after = CNT_W'(fill_reg + 1'b1);
            end
            KIND_REMOVE:
            begin
                ok         = (pos_ext < fill_ext);
                op         = CELL_SHIFT_DOWN;
                fill_after = CNT_W'(fill_reg - 1'b1);
            end
            KIND_READ:
            begin
                ok           = (pos_ext < fill_ext);
                returns_word = 1'b1;
            end
            KIND_OVERWRITE:
            begin
                ok = (pos_ext < fill_ext);
                op = CELL_WRITE;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Drop the cell command unless the transaction is accepted and legal
    always_comb
    begin
        ctrl.op        = (accept && ok) ? op : CELL_HOLD;
        ctrl.target    = target;
        ctrl.rd_target = rd_target;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [STORE_W-1:0] lower;
            logic [STORE_W-1:0] upper;

            if (gi == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_inner_lo
                assign lower = cell_word[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_inner_hi
                assign upper = cell_word[gi+1];
            end

            iidl_cell #(
                .WIDTH (STORE_W),
                .INDEX (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .value      (store_value),
                .lower_word (lower),
                .upper_word (upper),
                .word       (cell_word[gi]),
                .rd_word    (cell_rd_word[gi])
            );
        end
    endgenerate

    // Only the selected cell drives a nonzero word; combine them
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_word = rd_word | cell_rd_word[i];
        end
    end

    // Response and count update
    always_comb
    begin
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (accept)
        begin
            if (ok)
                fill_next = fill_after;
            rsp_valid_next       = 1'b1;
            rsp_next.status      = !ok;
            rsp_next.read_value  = (ok && returns_word) ? VALUE_W'(rd_word) : '0;
            rsp_next.entry_count = ok ? COUNT_W'(fill_after) : COUNT_W'(fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Count never passes the capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_COUNT)
        else $error("fill count above capacity");

    // Every accepted transaction leaves a response behind
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no response");

    // A rejected request leaves the count alone
    a_err_stable: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !ok |=> $stable(fill_reg))
        else $error("error request changed fill count");

    // The reported count matches the count held after the request
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_reg.entry_count == COUNT_W'(fill_reg))
        else $error("response count differs from fill count");

    // Errors never return a word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status |-> rsp_reg.read_value == '0)
        else $error("error response carries a word");

endmodule

`default_nettype wire
